>>> rtl/shc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the strip hit clusterer.
package shc_pkg;

	localparam int STRIP_BITS  = 11;
	localparam int TOT_BITS    = 8;
	localparam int LADDER_BITS = 12;
	localparam int BAD_BITS    = 12;
	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;

	// Strip span (width of a cluster, or a strip number plus one).
	localparam int SPAN_BITS = STRIP_BITS + 1;

	localparam logic [BAD_BITS-1:0] MAX_BAD = BAD_BITS'(10);
	localparam logic [BAD_BITS-1:0] BAD_SAT = {BAD_BITS{1'b1}};

	// Shared restoring divider geometry.
	localparam int REM_STEPS  = SPAN_BITS;
	localparam int DIV_STEPS  = (REM_STEPS > TOT_BITS) ? REM_STEPS : TOT_BITS;
	localparam int NUM_BITS   = TOT_BITS + SPAN_BITS;
	localparam int DIVR_BITS  = (LADDER_BITS > SPAN_BITS) ? LADDER_BITS : SPAN_BITS;
	localparam int DS_BITS    = DIVR_BITS + DIV_STEPS - 1;
	localparam int CMP_BITS   = (NUM_BITS > DS_BITS) ? NUM_BITS : DS_BITS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

	typedef enum logic [1:0] {
		SIDE_LOW  = 2'd0,
		SIDE_HIGH = 2'd1,
		SIDE_SPAN = 2'd2
	} side_t;

	typedef struct packed {
		logic [STRIP_BITS-1:0] strip;
		logic                  is_bad;
		logic                  is_final;
	} hit_item_t;

	typedef struct packed {
		logic [STRIP_BITS-1:0] first_strip;
		logic [STRIP_BITS-1:0] final_strip;
		logic [BAD_BITS-1:0]   bad_strips;
		side_t                 controller_side;
		logic [TOT_BITS-1:0]   raw_tot;
		logic                  run_end;
	} cluster_item_t;

	typedef struct packed {
		logic                   keep_all_clusters;
		logic [LADDER_BITS-1:0] strips_per_ladder;
		logic [STRIP_BITS-1:0]  split_strip;
		logic [TOT_BITS-1:0]    tot_low;
		logic [TOT_BITS-1:0]    tot_high;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_hit;
		logic rem_start;
		logic rem_load;
		logic join_hit;
		logic close;
		logic side_eval;
		logic div_start;
		logic div_load;
		logic push;
		logic run_end;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_rem;
		logic brk;
		logic keep_open;
		logic is_final;
		logic span;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/shc_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module shc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [shc_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [shc_pkg::DATA_BITS-1:0]  pwdata,
	output logic [shc_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output shc_pkg::cfg_t                  cfg,
	output logic                           ladder_wr
);
	import shc_pkg::*;

	localparam int IDX_BITS = ADDR_BITS - 2;
	localparam logic [IDX_BITS-1:0] REG_KEEP_ALL = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_LADDER   = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] REG_SPLIT    = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] REG_TOT_LOW  = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] REG_TOT_HIGH = IDX_BITS'(4);

	cfg_t                cfg_q;
	logic                wr_en;
	logic [IDX_BITS-1:0] idx;

	assign pready    = 1'b1;
	assign idx       = paddr[ADDR_BITS-1:2];
	assign wr_en     = psel && penable && pwrite && pready;
	assign ladder_wr = wr_en && (idx == REG_LADDER);
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keep_all_clusters <= 1'b0;
			cfg_q.strips_per_ladder <= LADDER_BITS'(384);
			cfg_q.split_strip       <= STRIP_BITS'(767);
			cfg_q.tot_low           <= '0;
			cfg_q.tot_high          <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_KEEP_ALL: cfg_q.keep_all_clusters <= pwdata[0];
				REG_LADDER:   cfg_q.strips_per_ladder <= pwdata[LADDER_BITS-1:0];
				REG_SPLIT:    cfg_q.split_strip       <= pwdata[STRIP_BITS-1:0];
				REG_TOT_LOW:  cfg_q.tot_low           <= pwdata[TOT_BITS-1:0];
				REG_TOT_HIGH: cfg_q.tot_high          <= pwdata[TOT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KEEP_ALL: prdata = DATA_BITS'(cfg_q.keep_all_clusters);
			REG_LADDER:   prdata = DATA_BITS'(cfg_q.strips_per_ladder);
			REG_SPLIT:    prdata = DATA_BITS'(cfg_q.split_strip);
			REG_TOT_LOW:  prdata = DATA_BITS'(cfg_q.tot_low);
			REG_TOT_HIGH: prdata = DATA_BITS'(cfg_q.tot_high);
			default:      prdata = '0;
		endcase
	end

endmodule

>>> rtl/shc_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
module shc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           rem_mode,
	input  logic [shc_pkg::NUM_BITS-1:0]   dividend,
	input  logic [shc_pkg::DIVR_BITS-1:0]  divisor,
	output logic                           busy,
	output logic [shc_pkg::DIV_STEPS-1:0]  quot,
	output logic [shc_pkg::NUM_BITS-1:0]   rem
);
	import shc_pkg::*;

	logic [STEP_BITS-1:0] cnt_q;
	logic [NUM_BITS-1:0]  acc_q;
	logic [DS_BITS-1:0]   ds_q;
	logic [DIV_STEPS-1:0] quot_q;
	logic                 ge;
	logic [CMP_BITS-1:0]  diff;

	assign busy = (cnt_q != '0);
	assign ge   = CMP_BITS'(acc_q) >= CMP_BITS'(ds_q);
	assign diff = CMP_BITS'(acc_q) - CMP_BITS'(ds_q);
	assign quot = quot_q;
	assign rem  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= rem_mode ? STEP_BITS'(REM_STEPS) : STEP_BITS'(TOT_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - STEP_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= dividend;
			quot_q <= '0;
			if (rem_mode) begin
				ds_q <= DS_BITS'(divisor) << (REM_STEPS - 1);
			end else begin
				ds_q <= DS_BITS'(divisor) << (TOT_BITS - 1);
			end
		end else if (busy) begin
			if (ge) begin
				acc_q <= diff[NUM_BITS-1:0];
			end
			quot_q <= {quot_q[DIV_STEPS-2:0], ge};
			ds_q   <= ds_q >> 1;
		end
	end

endmodule

>>> rtl/shc_datapath.sv
`timescale 1ns / 1ps
// Cluster datapath: open cluster, ladder remainder, emission math, result register.
module shc_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  shc_pkg::cfg_t          cfg,
	input  logic                   ladder_wr,
	input  shc_pkg::hit_item_t     hit,
	input  shc_pkg::cmd_t          cmd,
	output shc_pkg::sts_t          sts,
	output logic                   cluster_valid,
	input  logic                   cluster_ready,
	output shc_pkg::cluster_item_t cluster
);
	import shc_pkg::*;

	hit_item_t              hit_q;
	logic                   open_q;
	logic [STRIP_BITS-1:0]  open_first_q;
	logic [STRIP_BITS-1:0]  open_high_q;
	logic [BAD_BITS-1:0]    open_bad_q;
	logic [LADDER_BITS-1:0] rem_q;
	logic                   rem_ok_q;

	logic [STRIP_BITS-1:0]  em_first_q;
	logic [STRIP_BITS-1:0]  em_last_q;
	logic [BAD_BITS-1:0]    em_bad_q;
	side_t                  side_q;
	logic [TOT_BITS-1:0]    tot_q;
	logic [NUM_BITS-1:0]    p_lo_q;
	logic [NUM_BITS-1:0]    p_hi_q;
	logic [SPAN_BITS-1:0]   den_q;

	cluster_item_t          cluster_q;
	logic                   cluster_valid_q;

	logic [SPAN_BITS-1:0]   strip_ext;
	logic [SPAN_BITS-1:0]   high_inc;
	logic [SPAN_BITS-1:0]   width;
	logic                   gap;
	logic                   adj;
	logic                   std_mode;
	logic                   brk;
	logic                   keep_open;
	logic [LADDER_BITS-1:0] rem_inc;
	logic [BAD_BITS-1:0]    bad_start;

	logic                   first_le;
	logic                   last_le;
	side_t                  side_nxt;
	logic [SPAN_BITS-1:0]   a_cnt;
	logic [SPAN_BITS-1:0]   b_cnt;

	logic                   div_start;
	logic [NUM_BITS-1:0]    div_dividend;
	logic [DIVR_BITS-1:0]   div_divisor;
	logic                   div_busy;
	logic [DIV_STEPS-1:0]   div_quot;
	logic [NUM_BITS-1:0]    div_rem;

	assign strip_ext = {1'b0, hit_q.strip};
	assign high_inc  = {1'b0, open_high_q} + SPAN_BITS'(1);
	assign width     = high_inc - {1'b0, open_first_q};
	assign gap       = strip_ext > high_inc;
	assign adj       = strip_ext == high_inc;
	assign std_mode  = !cfg.keep_all_clusters && (cfg.strips_per_ladder != '0);
	assign brk       = open_q && (gap || (std_mode && adj && rem_ok_q && (rem_q == '0)));
	assign keep_open = cfg.keep_all_clusters ||
		(((SPAN_BITS + BAD_BITS)'(open_bad_q) < (SPAN_BITS + BAD_BITS)'(width)) &&
		 (open_bad_q <= MAX_BAD));
	assign rem_inc   = rem_q + LADDER_BITS'(1);
	assign bad_start = BAD_BITS'(hit_q.is_bad);

	assign sts.need_rem  = open_q && std_mode && adj && !rem_ok_q;
	assign sts.brk       = brk;
	assign sts.keep_open = keep_open;
	assign sts.is_final  = hit_q.is_final;
	assign sts.span      = (side_nxt == SIDE_SPAN);
	assign sts.div_busy  = div_busy;
	assign sts.out_free  = !cluster_valid_q || cluster_ready;

	// Side and weighting counts of the cluster being emitted.
	assign first_le = em_first_q <= cfg.split_strip;
	assign last_le  = em_last_q <= cfg.split_strip;
	assign a_cnt    = {1'b0, cfg.split_strip} - {1'b0, em_first_q} + SPAN_BITS'(1);
	assign b_cnt    = {1'b0, em_last_q} - {1'b0, cfg.split_strip};

	always_comb begin
		if (!first_le) begin
			side_nxt = SIDE_HIGH;
		end else if (last_le) begin
			side_nxt = SIDE_LOW;
		end else begin
			side_nxt = SIDE_SPAN;
		end
	end

	assign div_start    = cmd.rem_start || cmd.div_start;
	assign div_dividend = cmd.rem_start ? NUM_BITS'(high_inc) : (p_lo_q + p_hi_q);
	assign div_divisor  = cmd.rem_start ? DIVR_BITS'(cfg.strips_per_ladder)
	                                    : DIVR_BITS'(den_q);

	shc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_mode (cmd.rem_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_hit) begin
			hit_q <= hit;
		end
	end

	// Open cluster and its ladder remainder, (open_high + 1) mod strips_per_ladder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			open_first_q <= '0;
			open_high_q  <= '0;
			open_bad_q   <= '0;
			rem_q        <= '0;
			rem_ok_q     <= 1'b0;
		end else begin
			if (cmd.join_hit) begin
				if (!open_q || brk) begin
					open_q       <= 1'b1;
					open_first_q <= hit_q.strip;
					open_high_q  <= hit_q.strip;
					open_bad_q   <= bad_start;
					rem_ok_q     <= 1'b0;
				end else begin
					if (strip_ext > {1'b0, open_high_q}) begin
						open_high_q <= hit_q.strip;
						rem_q <= (rem_inc == cfg.strips_per_ladder) ? '0 : rem_inc;
					end
					if (hit_q.is_bad && (open_bad_q != BAD_SAT)) begin
						open_bad_q <= open_bad_q + BAD_BITS'(1);
					end
				end
			end
			if (cmd.close) begin
				open_q   <= 1'b0;
				rem_ok_q <= 1'b0;
			end
			if (cmd.rem_load) begin
				rem_q    <= div_rem[LADDER_BITS-1:0];
				rem_ok_q <= 1'b1;
			end
			if (ladder_wr) begin
				rem_ok_q <= 1'b0;
			end
		end
	end

	// Emission snapshot and the raw time over threshold.
	always_ff @(posedge clk) begin
		if ((cmd.join_hit && brk) || cmd.close) begin
			em_first_q <= open_first_q;
			em_last_q  <= open_high_q;
			em_bad_q   <= open_bad_q;
		end
		if (cmd.side_eval) begin
			side_q <= side_nxt;
			tot_q  <= (side_nxt == SIDE_HIGH) ? cfg.tot_high : cfg.tot_low;
			p_lo_q <= NUM_BITS'(cfg.tot_low) * NUM_BITS'(a_cnt);
			p_hi_q <= NUM_BITS'(cfg.tot_high) * NUM_BITS'(b_cnt);
			den_q  <= {1'b0, em_last_q} - {1'b0, em_first_q} + SPAN_BITS'(1);
		end
		if (cmd.div_load) begin
			tot_q <= div_quot[TOT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			cluster_q.first_strip     <= em_first_q;
			cluster_q.final_strip     <= em_last_q;
			cluster_q.bad_strips      <= em_bad_q;
			cluster_q.controller_side <= side_q;
			cluster_q.raw_tot         <= tot_q;
			cluster_q.run_end         <= cmd.run_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_valid_q <= 1'b0;
		end else if (cmd.push) begin
			cluster_valid_q <= 1'b1;
		end else if (cluster_ready) begin
			cluster_valid_q <= 1'b0;
		end
	end

	assign cluster_valid = cluster_valid_q;
	assign cluster       = cluster_q;

endmodule

>>> rtl/shc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing join, flush and emission.
module shc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hit_valid,
	output logic          hit_ready,
	input  shc_pkg::sts_t sts,
	output shc_pkg::cmd_t cmd
);
	import shc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_JOIN,
		S_REM,
		S_FIN,
		S_EM,
		S_DIVST,
		S_DIV,
		S_PUSH
	} state_t;

	state_t state_q;
	logic   em_pend_q;
	logic   run_end_q;
	logic   fin_emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			em_pend_q  <= 1'b0;
			run_end_q  <= 1'b0;
			fin_emit_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (hit_valid) begin
						state_q <= S_JOIN;
					end
				end
				S_JOIN: begin
					if (sts.need_rem) begin
						state_q <= S_REM;
					end else begin
						em_pend_q <= sts.brk && sts.keep_open;
						if ((sts.brk && sts.keep_open) || sts.is_final) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_REM: begin
					if (!sts.div_busy) begin
						state_q <= S_JOIN;
					end
				end
				S_FIN: begin
					if (em_pend_q) begin
						em_pend_q  <= 1'b0;
						run_end_q  <= !(sts.is_final && sts.keep_open);
						fin_emit_q <= 1'b0;
						state_q    <= S_EM;
					end else if (sts.is_final && sts.keep_open) begin
						run_end_q  <= 1'b1;
						fin_emit_q <= 1'b1;
						state_q    <= S_EM;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EM: begin
					state_q <= sts.span ? S_DIVST : S_PUSH;
				end
				S_DIVST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!sts.div_busy) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (sts.out_free) begin
						state_q <= fin_emit_q ? S_IDLE : S_FIN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign hit_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load_hit  = (state_q == S_IDLE) && hit_valid;
		cmd.rem_start = (state_q == S_JOIN) && sts.need_rem;
		cmd.join_hit  = (state_q == S_JOIN) && !sts.need_rem;
		cmd.rem_load  = (state_q == S_REM) && !sts.div_busy;
		cmd.close     = (state_q == S_FIN) && !em_pend_q && sts.is_final;
		cmd.side_eval = (state_q == S_EM);
		cmd.div_start = (state_q == S_DIVST);
		cmd.div_load  = (state_q == S_DIV) && !sts.div_busy;
		cmd.push      = (state_q == S_PUSH) && sts.out_free;
		cmd.run_end   = run_end_q;
	end

endmodule

>>> rtl/strip_hit_clusterer_core.sv
`timescale 1ns / 1ps
// Top level of the strip hit clusterer: register file, controller and datapath.
//
// Channel   Direction  Handshake                         Payload
// hit       in         hit_valid / hit_ready             hit_item_t (strip, is_bad, is_final)
// cluster   out        cluster_valid / cluster_ready     cluster_item_t (one kept cluster)
// config    in         psel, penable, pwrite, pready     paddr, pwdata, prdata (32 bits)
//
// An ordinary strip item is accepted, then joins or breaks the open cluster.
// A kept cluster closed by a gap or ladder edge adds the steps decide, side,
// push and decide again; otherwise the final flag adds a decide step, and a
// kept flushed cluster adds side and push.
// After a cluster opens or the ladder size is written, the first contiguous
// strip in standard mode waits for the ladder remainder.
// A cluster spanning the split strip adds a division for the strip-weighted
// average, and an emission waits while the result register stays stalled.
// Reset is asynchronous and needs no clearing pass; the result register
// lets the next item in while a finished item still waits to be taken.
module strip_hit_clusterer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hit_valid,
	output logic                           hit_ready,
	input  shc_pkg::hit_item_t             hit,
	output logic                           cluster_valid,
	input  logic                           cluster_ready,
	output shc_pkg::cluster_item_t         cluster,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [shc_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [shc_pkg::DATA_BITS-1:0]  pwdata,
	output logic [shc_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready
);
	import shc_pkg::*;

	cfg_t cfg;
	logic ladder_wr;
	cmd_t cmd;
	sts_t sts;

	// Hold the configuration; flag ladder-size writes so the cached
	// remainder gets dropped.
	shc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.ladder_wr (ladder_wr)
	);

	// Sequence each item: join, optional break emission, flush on final.
	shc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the open cluster, compute side and time over threshold, and
	// drive the result register.
	shc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.ladder_wr     (ladder_wr),
		.hit           (hit),
		.cmd           (cmd),
		.sts           (sts),
		.cluster_valid (cluster_valid),
		.cluster_ready (cluster_ready),
		.cluster       (cluster)
	);

endmodule

>>> rtl/shc_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the strip hit clusterer and its bind.
module shc_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   hit_valid,
	input logic                   hit_ready,
	input logic                   cluster_valid,
	input logic                   cluster_ready,
	input shc_pkg::cluster_item_t cluster
);
	import shc_pkg::*;

	// A stalled result item holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		cluster_valid && !cluster_ready |=> cluster_valid && $stable(cluster))
		else $error("stalled cluster item changed");

	// One item at a time: the block drops ready after taking an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_ready |=> !hit_ready)
		else $error("hit accepted back to back");

	// A cluster never ends below its first strip.
	assert property (@(posedge clk) disable iff (!arst_n)
		cluster_valid |-> cluster.first_strip <= cluster.final_strip)
		else $error("cluster strip range inverted");

	// A cluster that spans the split strip holds at least two strips.
	assert property (@(posedge clk) disable iff (!arst_n)
		cluster_valid && (cluster.controller_side == SIDE_SPAN)
		|-> cluster.first_strip != cluster.final_strip)
		else $error("spanning cluster of one strip");

endmodule

bind strip_hit_clusterer_core shc_checker u_shc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.hit_valid     (hit_valid),
	.hit_ready     (hit_ready),
	.cluster_valid (cluster_valid),
	.cluster_ready (cluster_ready),
	.cluster       (cluster)
);
